/* rtl/core/rctdm_pkg.sv */
package rctdm_pkg;

    typedef logic [10:0]        chan_t;
    typedef logic [6:0]         pct_t;
    typedef logic signed [7:0]  speed_t;
    typedef logic [6:0]         smag_t;
    typedef logic [2:0]         cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t REG_CENTER    = 3'd0;
    localparam cfg_idx_t REG_ENABLE    = 3'd1;
    localparam cfg_idx_t REG_SWITCH_ON = 3'd2;
    localparam cfg_idx_t REG_DEADZONE  = 3'd3;
    localparam cfg_idx_t REG_LOW_PCT   = 3'd4;

    localparam chan_t CENTER_RESET    = 11'd1500;
    localparam chan_t ENABLE_RESET    = 11'd1050;
    localparam chan_t SWITCH_ON_RESET = 11'd1950;
    localparam pct_t  DEADZONE_RESET  = 7'd3;
    localparam pct_t  LOW_PCT_RESET   = 7'd20;

    localparam smag_t SPEED_MAX = 7'd100;
    localparam pct_t  PCT_FULL  = 7'd100;

    // floor(m / 9) = (m * 7282) >> 16, exact for m below 32768
    localparam logic [12:0] DIV9_RECIP    = 13'd7282;
    // floor(m / 100) = (m * 10486) >> 20, exact for m below 43690
    localparam logic [13:0] DIV100_RECIP  = 14'd10486;

    // two's complement speed from sign and magnitude
    function automatic speed_t to_speed(input logic neg, input smag_t m);
        logic [7:0] ext;
        ext = {1'b0, m};
        return neg ? speed_t'(8'd0 - ext) : speed_t'(ext);
    endfunction

    function automatic smag_t speed_mag(input speed_t v);
        logic [7:0] neg_v;
        neg_v = 8'd0 - v;
        return v[7] ? neg_v[6:0] : v[6:0];
    endfunction

endpackage

/* rtl/core/rctdm_frame_if.sv */
interface rctdm_frame_if import rctdm_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t steer_channel;
    chan_t forward_channel;
    chan_t alt_steer_channel;
    chan_t enable_channel;
    chan_t single_hand_channel;
    chan_t low_speed_channel;

    modport source (
        output valid, steer_channel, forward_channel, alt_steer_channel,
               enable_channel, single_hand_channel, low_speed_channel,
        input  ready
    );
    modport sink (
        input  valid, steer_channel, forward_channel, alt_steer_channel,
               enable_channel, single_hand_channel, low_speed_channel,
        output ready
    );
endinterface

/* rtl/core/rctdm_speed_if.sv */
interface rctdm_speed_if import rctdm_pkg::*; ();
    logic   valid;
    logic   ready;
    speed_t left_track;
    speed_t right_track;

    modport source (
        output valid, left_track, right_track,
        input  ready
    );
    modport sink (
        input  valid, left_track, right_track,
        output ready
    );
endinterface

/* rtl/core/rctdm_map.sv */
module rctdm_map import rctdm_pkg::*; (
    input  chan_t  chan,
    input  chan_t  center,
    output speed_t comp
);

    logic signed [11:0] diff;
    logic [11:0]        diff_neg;
    logic [10:0]        dmag;
    logic [12:0]        rmag;
    logic [25:0]        prod;
    logic [9:0]         quo;
    smag_t              qsat;

    assign diff     = $signed({1'b0, chan}) - $signed({1'b0, center});
    assign diff_neg = 12'd0 - diff;
    assign dmag     = diff[11] ? diff_neg[10:0] : diff[10:0];

    // doubled magnitude plus four, then divide by nine: round to nearest, ties away from zero
    assign rmag = {1'b0, dmag, 1'b0} + 13'd4;
    assign prod = rmag * DIV9_RECIP;
    assign quo  = prod[25:16];
    assign qsat = (quo > {3'd0, SPEED_MAX}) ? SPEED_MAX : quo[6:0];

    assign comp = to_speed(diff[11], qsat);

endmodule

/* rtl/core/rc_channel_tank_drive_mixer.sv */
// Tank-drive mixer: each request carries one frame of six radio-control channel values and,
// when the enable channel equals enable_reg, yields one left/right track speed pair in
// -100..100; frames with any other enable value are consumed and yield nothing. A new frame
// is taken every cycle unless the full pipeline is stalled; its stages are the input register,
// channel mapping with a multiply by the reciprocal of nine, a percent scaling multiply, and a
// divide by one hundred through a reciprocal multiply followed by deadzone and mixing.
// Each stage holds while its successor is full, so a waiting result never blocks intake until
// the pipeline fills. Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// and should only change while no frame is in flight.
module rc_channel_tank_drive_mixer import rctdm_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  cfg_idx_t      cfg_index,
    input  chan_t         cfg_data,
    rctdm_frame_if.sink   frame,
    rctdm_speed_if.source speed
);

    // configuration
    chan_t center_reg;
    chan_t enable_reg;
    chan_t switch_on_reg;
    pct_t  deadzone_reg;
    pct_t  low_pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg    <= CENTER_RESET;
            enable_reg    <= ENABLE_RESET;
            switch_on_reg <= SWITCH_ON_RESET;
            deadzone_reg  <= DEADZONE_RESET;
            low_pct_reg   <= LOW_PCT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER:    center_reg    <= cfg_data;
                REG_ENABLE:    enable_reg    <= cfg_data;
                REG_SWITCH_ON: switch_on_reg <= cfg_data;
                REG_DEADZONE:  deadzone_reg  <= cfg_data[6:0];
                REG_LOW_PCT:   low_pct_reg   <= cfg_data[6:0];
                default:       ;
            endcase
        end
    end

    // pipeline control
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic rdy0, rdy1, rdy2, rdy_out;

    assign rdy_out     = !out_valid_reg || speed.ready;
    assign rdy2        = !s2_valid_reg  || rdy_out;
    assign rdy1        = !s1_valid_reg  || rdy2;
    assign rdy0        = !s0_valid_reg  || rdy1;
    assign frame.ready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // disabled frames are dropped at intake
            if (rdy0)
                s0_valid_reg <= frame.valid && (frame.enable_channel == enable_reg);
            if (rdy1)
                s1_valid_reg <= s0_valid_reg;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // stage 0: input register
    chan_t s0_steer_reg, s0_fwd_reg, s0_alt_reg, s0_single_reg, s0_low_reg;

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            s0_steer_reg  <= frame.steer_channel;
            s0_fwd_reg    <= frame.forward_channel;
            s0_alt_reg    <= frame.alt_steer_channel;
            s0_single_reg <= frame.single_hand_channel;
            s0_low_reg    <= frame.low_speed_channel;
        end
    end

    // stage 1: channel mapping
    chan_t  lr_chan;
    speed_t fb_map, lr_map;

    assign lr_chan = (s0_single_reg == switch_on_reg) ? s0_alt_reg : s0_steer_reg;

    rctdm_map u_map_fb (
        .chan   (s0_fwd_reg),
        .center (center_reg),
        .comp   (fb_map)
    );

    rctdm_map u_map_lr (
        .chan   (lr_chan),
        .center (center_reg),
        .comp   (lr_map)
    );

    speed_t s1_fb_reg, s1_lr_reg;
    logic   s1_low_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_fb_reg  <= fb_map;
            s1_lr_reg  <= lr_map;
            s1_low_reg <= (s0_low_reg == switch_on_reg);
        end
    end

    // stage 2: percent scaling, full scale is one hundred percent when low speed is off
    pct_t        pct_eff;
    logic [13:0] fb_prod, lr_prod;

    assign pct_eff = s1_low_reg ? low_pct_reg : PCT_FULL;
    assign fb_prod = speed_mag(s1_fb_reg) * pct_eff;
    assign lr_prod = speed_mag(s1_lr_reg) * pct_eff;

    logic [13:0] s2_fb_prod_reg, s2_lr_prod_reg;
    logic        s2_fb_neg_reg, s2_lr_neg_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_fb_prod_reg <= fb_prod;
            s2_lr_prod_reg <= lr_prod;
            s2_fb_neg_reg  <= s1_fb_reg[7];
            s2_lr_neg_reg  <= s1_lr_reg[7];
        end
    end

    // stage 3: divide by one hundred, deadzone, mixing
    logic [27:0] fb_quo_full, lr_quo_full;
    smag_t       fb_quo, lr_quo, fmag, smag_raw, smag;
    speed_t      fb_val, lr_val, lr_inv, inner;
    speed_t      left_next, right_next;

    assign fb_quo_full = s2_fb_prod_reg * DIV100_RECIP;
    assign lr_quo_full = s2_lr_prod_reg * DIV100_RECIP;
    assign fb_quo      = fb_quo_full[26:20];
    assign lr_quo      = lr_quo_full[26:20];
    assign fmag        = (fb_quo > SPEED_MAX) ? SPEED_MAX : fb_quo;
    assign smag_raw    = (lr_quo > SPEED_MAX) ? SPEED_MAX : lr_quo;
    assign smag        = (smag_raw <= deadzone_reg) ? 7'd0 : smag_raw;

    assign fb_val = to_speed(s2_fb_neg_reg, fmag);
    assign lr_val = to_speed(s2_lr_neg_reg, smag);
    assign lr_inv = to_speed(!s2_lr_neg_reg, smag);
    // inner track slows by the steering amount and stops once steering exceeds forward
    assign inner  = (fmag < smag) ? speed_t'(8'sd0)
                                  : to_speed(s2_fb_neg_reg, fmag - smag);

    always_comb
    begin
        priority if (fmag == 7'd0)
        begin
            left_next  = lr_val;
            right_next = lr_inv;
        end
        else if (smag == 7'd0)
        begin
            left_next  = fb_val;
            right_next = fb_val;
        end
        else if (!s2_lr_neg_reg)
        begin
            left_next  = fb_val;
            right_next = inner;
        end
        else
        begin
            left_next  = inner;
            right_next = fb_val;
        end
    end

    speed_t left_reg, right_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign speed.valid       = out_valid_reg;
    assign speed.left_track  = left_reg;
    assign speed.right_track = right_reg;

endmodule

/* rtl/core/rctdm_checker.sv */
module rctdm_checker import rctdm_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    input logic   frame_valid,
    input logic   frame_ready,
    input logic   speed_valid,
    input logic   speed_ready,
    input speed_t left_track,
    input speed_t right_track
);

    // no result can be pending as reset is released
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !speed_valid)
        else $error("result valid out of reset");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_valid |-> (left_track >= -8'sd100) && (left_track <= 8'sd100)
                     && (right_track >= -8'sd100) && (right_track <= 8'sd100))
        else $error("track speed out of range");

    // tracks only run in opposite directions when turning in place
    a_spin_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_valid && left_track != 8'sd0 && right_track != 8'sd0
         && left_track[7] != right_track[7])
        |-> (left_track == speed_t'(8'sd0 - right_track)))
        else $error("opposite track directions without a spin");

    // with an empty result register every stage drains, so intake is open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !speed_valid |-> frame_ready)
        else $error("frame refused while output is empty");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_valid && !speed_ready)
        |=> speed_valid && $stable(left_track) && $stable(right_track))
        else $error("stalled result changed");

endmodule

bind rc_channel_tank_drive_mixer rctdm_checker u_rctdm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .speed_valid (speed.valid),
    .speed_ready (speed.ready),
    .left_track  (speed.left_track),
    .right_track (speed.right_track)
);

/* tb/tank_mix_checker.sv */
module tank_mix_checker import rctdm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_wr_en,
    input  cfg_idx_t cfg_index,
    input  chan_t    cfg_data,
    rctdm_frame_if   frame,
    rctdm_speed_if   speed,
    output int       failures,
    output int       pending
);

    typedef struct packed {
        speed_t left;
        speed_t right;
    } track_cmd_t;

    chan_t center_code;
    chan_t enable_code;
    chan_t switch_on_code;
    pct_t  steer_deadzone;
    pct_t  low_pct;

    track_cmd_t expected_cmds[$];

    function automatic int clamp_speed(input int v);
        if (v > 100)
            return 100;
        if (v < -100)
            return -100;
        return v;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // rounds half away from zero: +-4 on the doubled offset before dividing by nine
    function automatic int stick_speed(input chan_t raw);
        int diff;
        diff = int'(raw) - int'(center_code);
        return clamp_speed((diff * 2 + ((diff >= 0) ? 4 : -4)) / 9);
    endfunction

    // slowed track in a differential turn, stops when steering outweighs forward
    function automatic int inner_speed(input int fwd, input int steer);
        int af;
        int as;
        af = magnitude(fwd);
        as = magnitude(steer);
        if (af < as)
            return 0;
        return (fwd > 0) ? af - as : as - af;
    endfunction

    function automatic bit mix_tracks(input chan_t steer, input chan_t fwd, input chan_t alt,
                                      input chan_t en, input chan_t single, input chan_t slow,
                                      output track_cmd_t cmd);
        int fb;
        int lr;
        int l;
        int r;
        cmd = '0;
        if (en != enable_code)
            return 1'b0;
        fb = stick_speed(fwd);
        lr = (single == switch_on_code) ? stick_speed(alt) : stick_speed(steer);
        if (slow == switch_on_code)
        begin
            fb = clamp_speed((fb * int'(low_pct)) / 100);
            lr = clamp_speed((lr * int'(low_pct)) / 100);
        end
        if (magnitude(lr) <= int'(steer_deadzone))
            lr = 0;
        if (fb == 0)
        begin
            l = lr;
            r = -lr;
        end
        else if (lr == 0)
        begin
            l = fb;
            r = fb;
        end
        else if (lr > 0)
        begin
            l = fb;
            r = inner_speed(fb, lr);
        end
        else
        begin
            l = inner_speed(fb, lr);
            r = fb;
        end
        cmd.left  = speed_t'(l);
        cmd.right = speed_t'(r);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        track_cmd_t want;
        track_cmd_t next_cmd;
        if (!rst_n)
        begin
            center_code    = CENTER_RESET;
            enable_code    = ENABLE_RESET;
            switch_on_code = SWITCH_ON_RESET;
            steer_deadzone = DEADZONE_RESET;
            low_pct        = LOW_PCT_RESET;
            expected_cmds.delete();
            pending  = 0;
            failures = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CENTER:    center_code    = cfg_data;
                    REG_ENABLE:    enable_code    = cfg_data;
                    REG_SWITCH_ON: switch_on_code = cfg_data;
                    REG_DEADZONE:  steer_deadzone = cfg_data[6:0];
                    REG_LOW_PCT:   low_pct        = cfg_data[6:0];
                    default: ;
                endcase
            end

            if (speed.valid && speed.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("speed request with no frame waiting: left %0d right %0d",
                           $signed(speed.left_track), $signed(speed.right_track));
                    failures++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (speed.left_track !== want.left)
                    begin
                        $error("left_track: expected %0d, got %0d",
                               $signed(want.left), $signed(speed.left_track));
                        failures++;
                    end
                    if (speed.right_track !== want.right)
                    begin
                        $error("right_track: expected %0d, got %0d",
                               $signed(want.right), $signed(speed.right_track));
                        failures++;
                    end
                end
            end

            if (frame.valid && frame.ready)
            begin
                if (mix_tracks(frame.steer_channel, frame.forward_channel,
                               frame.alt_steer_channel, frame.enable_channel,
                               frame.single_hand_channel, frame.low_speed_channel, next_cmd))
                    expected_cmds.push_back(next_cmd);
            end
            pending = expected_cmds.size();
        end
    end

endmodule

/* tb/tb_top.sv */
module tb_top;
    import rctdm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 80;

    typedef struct {
        chan_t steer_channel;
        chan_t forward_channel;
        chan_t alt_steer_channel;
        chan_t enable_channel;
        chan_t single_hand_channel;
        chan_t low_speed_channel;
    } frame_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_wr_en;
    cfg_idx_t cfg_index;
    chan_t    cfg_data;

    int failures;
    int pending;
    int cycle_count = 0;

    // stimulus-side view of the registers, used to aim the random and directed frames
    int cur_center;
    int cur_enable;
    int cur_switch;

    bit quiet = 1'b0;
    bit pressure_go = 1'b0;

    rctdm_frame_if frame_ch ();
    rctdm_speed_if speed_ch ();

    rc_channel_tank_drive_mixer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_ch),
        .speed     (speed_ch)
    );

    tank_mix_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_ch),
        .speed     (speed_ch),
        .failures  (failures),
        .pending   (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // speed sink: short runs and stalls, the odd long stall, one long hold-off
    initial
    begin
        int  run_left;
        int  stall_left;
        bit  pressure_seen;
        run_left = 0;
        stall_left = 0;
        pressure_seen = 1'b0;
        speed_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_go && !pressure_seen)
            begin
                pressure_seen = 1'b1;
                stall_left = HOLD_CYCLES;
                run_left = 0;
            end
            if (stall_left == 0 && run_left == 0)
            begin
                if (quiet || $urandom_range(0, 2) != 0)
                    run_left = $urandom_range(1, 20);
                else if ($urandom_range(0, 9) < 8)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(10, 40);
            end
            if (stall_left > 0)
            begin
                speed_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                speed_ch.ready <= 1'b1;
                run_left--;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 17)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic chan_t rel(input int off);
        int v;
        v = cur_center + off;
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return chan_t'(v);
    endfunction

    function automatic chan_t pick_stick();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return chan_t'($urandom_range(0, 2047));
        if (r < 7)
            return rel(int'($urandom_range(0, 920)) - 460);
        if (r < 9)
            return rel(int'($urandom_range(0, 50)) - 25);
        return rel(0);
    endfunction

    function automatic chan_t pick_switch();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return chan_t'(cur_switch);
        if (r == 4)
            return chan_t'(cur_switch + ($urandom_range(0, 1) ? 1 : -1));
        return chan_t'($urandom_range(0, 2047));
    endfunction

    function automatic chan_t pick_enable();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return chan_t'(cur_enable);
        if (r == 8)
            return chan_t'(cur_enable + ($urandom_range(0, 1) ? 1 : -1));
        return chan_t'($urandom_range(0, 2047));
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.steer_channel       = pick_stick();
        f.forward_channel     = pick_stick();
        f.alt_steer_channel   = pick_stick();
        f.enable_channel      = pick_enable();
        f.single_hand_channel = pick_switch();
        f.low_speed_channel   = pick_switch();
        return f;
    endfunction

    // valid stays high straight into the next request when there is no gap
    task automatic send_frame(input frame_t f, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            frame_ch.valid <= 1'b0;
        end
        @(negedge clk);
        frame_ch.valid               <= 1'b1;
        frame_ch.steer_channel       <= f.steer_channel;
        frame_ch.forward_channel     <= f.forward_channel;
        frame_ch.alt_steer_channel   <= f.alt_steer_channel;
        frame_ch.enable_channel      <= f.enable_channel;
        frame_ch.single_hand_channel <= f.single_hand_channel;
        frame_ch.low_speed_channel   <= f.low_speed_channel;
        do
            @(posedge clk);
        while (!frame_ch.ready);
    endtask

    task automatic send_fields(input chan_t steer, input chan_t fwd, input chan_t alt,
                               input chan_t en, input chan_t single, input chan_t slow);
        frame_t f;
        f.steer_channel       = steer;
        f.forward_channel     = fwd;
        f.alt_steer_channel   = alt;
        f.enable_channel      = en;
        f.single_hand_channel = single;
        f.low_speed_channel   = slow;
        send_frame(f, sender_gap());
    endtask

    // wait until no expected result is pending, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= chan_t'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input int center, input int enable, input int switch_on,
                              input int deadzone, input int pct);
        write_reg(REG_CENTER, center);
        write_reg(REG_ENABLE, enable);
        write_reg(REG_SWITCH_ON, switch_on);
        write_reg(REG_DEADZONE, deadzone);
        write_reg(REG_LOW_PCT, pct);
        cur_center = center;
        cur_enable = enable;
        cur_switch = switch_on;
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            quiet = (i >= n / 4) && (i < n / 4 + 20);
            send_frame(random_frame(), sender_gap());
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        chan_t en;
        chan_t sw;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_CENTER;
        cfg_data = '0;
        frame_ch.valid = 1'b0;
        frame_ch.steer_channel = '0;
        frame_ch.forward_channel = '0;
        frame_ch.alt_steer_channel = '0;
        frame_ch.enable_channel = '0;
        frame_ch.single_hand_channel = '0;
        frame_ch.low_speed_channel = '0;
        cur_center = int'(CENTER_RESET);
        cur_enable = int'(ENABLE_RESET);
        cur_switch = int'(SWITCH_ON_RESET);
        en = ENABLE_RESET;
        sw = SWITCH_ON_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed frames under the reset configuration
        send_fields(rel(0), rel(0), rel(0), en - 1'b1, 11'd0, 11'd0);
        send_fields(rel(0), rel(0), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(0), 11'd2047, rel(0), en, 11'd0, 11'd0);
        send_fields(rel(0), 11'd0, rel(0), en, 11'd0, 11'd0);
        send_fields(11'd2047, rel(0), rel(0), en, 11'd0, 11'd0);
        send_fields(11'd0, rel(0), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(90), rel(225), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(-90), rel(225), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(90), rel(-225), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(-90), rel(-225), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(300), rel(100), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(-300), rel(-100), rel(0), en, 11'd0, 11'd0);
        // steering of exactly the deadzone, then one step past it
        send_fields(rel(13), rel(200), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(16), rel(200), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(-13), rel(0), rel(0), en, 11'd0, 11'd0);
        // rounding just above and just below the half step
        send_fields(rel(3), rel(2), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(-3), rel(-2), rel(0), en, 11'd0, 11'd0);
        send_fields(rel(0), rel(300), rel(300), en, sw, 11'd0);
        send_fields(rel(200), rel(-400), rel(0), en, sw - 1'b1, sw);
        send_fields(11'd0, 11'd2047, 11'd2047, en, sw, sw);
        send_fields(11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047);
        send_fields(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
        drain();

        set_config(int'(CENTER_RESET), int'(ENABLE_RESET), int'(SWITCH_ON_RESET),
                   int'(DEADZONE_RESET), int'(LOW_PCT_RESET));
        run_random(ITEMS_PER_PHASE);
        // hold the sink off while requests keep coming so the pipeline backs up
        pressure_go = 1'b1;
        quiet = 1'b1;
        for (int i = 0; i < 30; i++)
            send_frame(random_frame(), 0);
        quiet = 1'b0;
        drain();

        set_config(1024, 0, 2047, 0, 100);
        run_random(ITEMS_PER_PHASE);
        drain();

        set_config(0, 2047, 0, 100, 0);
        run_random(ITEMS_PER_PHASE);
        drain();

        set_config(2047, 1234, 777, 127, 127);
        run_random(ITEMS_PER_PHASE);
        drain();

        set_config(900, 5, 1800, 10, 55);
        run_random(ITEMS_PER_PHASE);
        drain();

        repeat (10) @(negedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
